### sv/assert_macros.svh
// assertion macros used by the checker file cco_check.sv
// depends on nothing; a clock named clock and a reset named reset must be in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// property checked also while reset is high
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

### sv/cco_pkg.sv
// types, widths and helper functions for the capsule overlap pipeline
// used by every module of the block
package cco_pkg;

   localparam int COORD_W = 16;
   localparam int POINT_W = 3 * COORD_W;
   localparam int RAD_W   = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int DOT_W   = 36;
   localparam int WIDE_W  = 2 * DOT_W;
   localparam int TNUM_W  = 56;
   localparam int PARAM_W = 17;
   localparam int DIST_W  = 40;
   localparam int RS_W    = RAD_W + 1;
   localparam int RS2_W   = 2 * RS_W;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int LIM_W   = 16;

   localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);
   localparam logic [LIM_W-1:0]   LIMIT_RESET = LIM_W'(1);

   typedef logic [2:0][COORD_W-1:0] coord3_type;
   typedef logic [2:0][DIFF_W-1:0]  diff3_type;

   typedef struct packed {
      logic [POINT_W-1:0] seg_a_start;
      logic [POINT_W-1:0] seg_a_end;
      logic [POINT_W-1:0] seg_b_start;
      logic [POINT_W-1:0] seg_b_end;
      logic [RAD_W-1:0]   radius_a;
      logic [RAD_W-1:0]   radius_b;
   } req_type;

   typedef struct packed {
      logic               overlap;
      logic [PARAM_W-1:0] param_s;
      logic [PARAM_W-1:0] param_t;
      logic [POINT_W-1:0] closest_on_a;
      logic [POINT_W-1:0] closest_on_b;
      logic [DIST_W-1:0]  dist_squared;
   } rsp_type;

   typedef struct packed {
      coord3_type p1;
      coord3_type q1;
      diff3_type  d1;
      diff3_type  d2;
   } geo_type;

   typedef struct packed {
      geo_type           geo;
      diff3_type         r;
      logic [RS2_W-1:0]  rs2;
   } st1_type;

   typedef struct packed {
      geo_type                  geo;
      logic [RS2_W-1:0]         rs2;
      logic signed [DOT_W-1:0]  a;
      logic signed [DOT_W-1:0]  b;
      logic signed [DOT_W-1:0]  c;
      logic signed [DOT_W-1:0]  e;
      logic signed [DOT_W-1:0]  f;
   } st2_type;

   typedef struct packed {
      st2_type                  dots;
      logic                     deg_a;
      logic                     deg_e;
   } side1_type;

   typedef struct packed {
      side1_type                side;
      logic signed [WIDE_W-1:0] ae;
      logic signed [WIDE_W-1:0] bb;
      logic signed [WIDE_W-1:0] bf;
      logic signed [WIDE_W-1:0] ce;
   } st3_type;

   typedef struct packed {
      side1_type                side;
      logic signed [WIDE_W-1:0] num;
      logic signed [WIDE_W-1:0] den;
   } st4_type;

   typedef struct packed {
      side1_type                side;
      logic [PARAM_W-1:0]       s0;
      logic signed [TNUM_W-1:0] tnum;
   } st5_type;

   typedef struct packed {
      geo_type             geo;
      logic [RS2_W-1:0]    rs2;
      logic                tgt_t;
      logic [PARAM_W-1:0]  fixed;
   } side2_type;

   typedef struct packed {
      side2_type                side;
      logic signed [TNUM_W-1:0] num;
      logic signed [TNUM_W-1:0] den;
   } st6_type;

   typedef struct packed {
      logic [PARAM_W-1:0] s;
      logic [PARAM_W-1:0] t;
      coord3_type         ca;
      coord3_type         cb;
      logic [RS2_W-1:0]   rs2;
   } st7_type;

   typedef struct packed {
      logic [PARAM_W-1:0]    s;
      logic [PARAM_W-1:0]    t;
      coord3_type            ca;
      coord3_type            cb;
      logic [RS2_W-1:0]      rs2;
      logic [2:0][SQ_W-1:0]  sq;
   } st8_type;

   function automatic logic [COORD_W-1:0] coord_of(logic [POINT_W-1:0] p, int k);
      return p[COORD_W*k +: COORD_W];
   endfunction

   function automatic logic signed [DOT_W-1:0] dot3(diff3_type x, diff3_type y);
      logic signed [DOT_W-1:0]    acc;
      logic signed [DIFF_W-1:0]   xs;
      logic signed [DIFF_W-1:0]   ys;
      logic signed [2*DIFF_W-1:0] pr;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         xs  = $signed(x[k]);
         ys  = $signed(y[k]);
         pr  = xs * ys;
         acc = acc + DOT_W'(pr);
      end
      return acc;
   endfunction

   // start + round(d * p / 2^16), ties toward plus infinity
   function automatic logic [COORD_W-1:0] along(logic [COORD_W-1:0] start,
                                                logic [DIFF_W-1:0] d,
                                                logic [PARAM_W-1:0] p);
      logic signed [DIFF_W+PARAM_W:0]   prod;
      logic signed [DIFF_W+PARAM_W+1:0] rnd;
      logic signed [COORD_W+3:0]        stp;
      logic signed [COORD_W+3:0]        sum;
      prod = $signed(d) * $signed({1'b0, p});
      rnd  = (DIFF_W+PARAM_W+2)'(prod) + (DIFF_W+PARAM_W+2)'(32768);
      stp  = (COORD_W+4)'(rnd >>> 16);
      sum  = (COORD_W+4)'($signed(start)) + stp;
      return sum[COORD_W-1:0];
   endfunction

endpackage

### sv/cco_frac.sv
// pipelined clamped fraction unit: q = clamp(num / den) in Q1.16, one bit per stage
// depends on cco_pkg
module cco_frac import cco_pkg::*; #(
   parameter int NUM_W  = TNUM_W,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [NUM_W-1:0]  in_num,
   input  logic signed [NUM_W-1:0]  in_den,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [PARAM_W-1:0]       out_q,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int STEPS = PARAM_W - 1;

   logic               v_ff    [0:STEPS];
   logic               done_ff [0:STEPS];
   logic [NUM_W-1:0]   rem_ff  [0:STEPS];
   logic [NUM_W-1:0]   den_ff  [0:STEPS];
   logic [PARAM_W-1:0] q_ff    [0:STEPS];
   logic [SIDE_W-1:0]  side_ff [0:STEPS];
   logic               rdy     [0:STEPS+1];

   assign rdy[STEPS+1] = out_ready;
   assign in_ready     = rdy[0];
   assign out_valid    = v_ff[STEPS];
   assign out_q        = q_ff[STEPS];
   assign out_side     = side_ff[STEPS];

   for (genvar k = 0; k <= STEPS; k++) begin : g_stage
      logic               vin;
      logic               done_in;
      logic [NUM_W-1:0]   rem_in;
      logic [NUM_W-1:0]   den_in;
      logic [PARAM_W-1:0] q_in;
      logic [SIDE_W-1:0]  side_in;

      assign rdy[k] = !v_ff[k] || rdy[k+1];

      if (k == 0) begin : g_pre
         logic nonpos;
         logic big;
         assign nonpos  = in_num[NUM_W-1] || (in_num == '0);
         assign big     = in_num >= in_den;
         assign vin     = in_valid;
         assign done_in = nonpos || big;
         assign q_in    = (!nonpos && big) ? ONE_Q16 : '0;
         assign rem_in  = in_num;
         assign den_in  = in_den;
         assign side_in = in_side;
      end else begin : g_step
         logic [NUM_W:0] rem2;
         logic [NUM_W:0] diff;
         logic           ge;
         // remainder stays below den, so the doubled value fits one extra bit
         assign rem2    = {rem_ff[k-1], 1'b0};
         assign diff    = rem2 - {1'b0, den_ff[k-1]};
         assign ge      = rem2 >= {1'b0, den_ff[k-1]};
         assign vin     = v_ff[k-1];
         assign done_in = done_ff[k-1];
         assign rem_in  = done_ff[k-1] ? rem_ff[k-1] :
                          (ge ? diff[NUM_W-1:0] : rem2[NUM_W-1:0]);
         assign q_in    = done_ff[k-1] ? q_ff[k-1] : {q_ff[k-1][PARAM_W-2:0], ge};
         assign den_in  = den_ff[k-1];
         assign side_in = side_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= vin;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && vin) begin
            done_ff[k] <= done_in;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_in;
            q_ff[k]    <= q_in;
            side_ff[k] <= side_in;
         end
      end
   end

endmodule

### sv/capsule_capsule_overlap_test.sv
// Capsule-capsule overlap test: closest points of two segments, squared distance and overlap.
// Fully pipelined: one item per cycle while results are taken; nine datapath stages plus two
// 17-stage fraction units, one for the unclamped s and one for the final s or t.
// Stalls on the result side collapse bubbles stage by stage; nothing is lost or repeated.
// depends on cco_pkg and cco_frac
module capsule_capsule_overlap_test import cco_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LIM_W-1:0] csr_data
);

   logic [LIM_W-1:0] limit_ff;
   logic [LIM_W-1:0] lim;

   assign csr_ready = 1'b1;
   assign lim = (limit_ff == '0) ? LIM_W'(1) : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // ready chain
   logic st1_v_ff, st2_v_ff, st3_v_ff, st4_v_ff, st5_v_ff, st6_v_ff;
   logic st7_v_ff, st8_v_ff, st9_v_ff;
   logic st1_rdy, st2_rdy, st3_rdy, st4_rdy, st5_rdy, st6_rdy, st7_rdy, st8_rdy, st9_rdy;
   logic f1_in_ready, f1_out_valid, f2_in_ready, f2_out_valid;

   st1_type st1_ff, st1_in;
   st2_type st2_ff, st2_in;
   st3_type st3_ff, st3_in;
   st4_type st4_ff, st4_in;
   st5_type st5_ff, st5_in;
   st6_type st6_ff, st6_in;
   st7_type st7_ff, st7_in;
   st8_type st8_ff, st8_in;
   rsp_type st9_ff, st9_in;

   logic [PARAM_W-1:0]          f1_q, f2_q;
   logic [$bits(side1_type)-1:0] f1_side_out;
   logic [$bits(side2_type)-1:0] f2_side_out;
   side1_type                   f1_side;
   side2_type                   f2_side;

   assign st9_rdy = !st9_v_ff || rsp_ready;
   assign st8_rdy = !st8_v_ff || st9_rdy;
   assign st7_rdy = !st7_v_ff || st8_rdy;
   assign st6_rdy = !st6_v_ff || f2_in_ready;
   assign st5_rdy = !st5_v_ff || st6_rdy;
   assign st4_rdy = !st4_v_ff || f1_in_ready;
   assign st3_rdy = !st3_v_ff || st4_rdy;
   assign st2_rdy = !st2_v_ff || st3_rdy;
   assign st1_rdy = !st1_v_ff || st2_rdy;

   assign req_ready = st1_rdy;
   assign rsp_valid = st9_v_ff;
   assign rsp_data  = st9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_v_ff <= 1'b0;
         st2_v_ff <= 1'b0;
         st3_v_ff <= 1'b0;
         st4_v_ff <= 1'b0;
         st5_v_ff <= 1'b0;
         st6_v_ff <= 1'b0;
         st7_v_ff <= 1'b0;
         st8_v_ff <= 1'b0;
         st9_v_ff <= 1'b0;
      end else begin
         if (st1_rdy) st1_v_ff <= req_valid;
         if (st2_rdy) st2_v_ff <= st1_v_ff;
         if (st3_rdy) st3_v_ff <= st2_v_ff;
         if (st4_rdy) st4_v_ff <= st3_v_ff;
         if (st5_rdy) st5_v_ff <= f1_out_valid;
         if (st6_rdy) st6_v_ff <= st5_v_ff;
         if (st7_rdy) st7_v_ff <= f2_out_valid;
         if (st8_rdy) st8_v_ff <= st7_v_ff;
         if (st9_rdy) st9_v_ff <= st8_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st1_rdy && req_valid)    st1_ff <= st1_in;
      if (st2_rdy && st1_v_ff)     st2_ff <= st2_in;
      if (st3_rdy && st2_v_ff)     st3_ff <= st3_in;
      if (st4_rdy && st3_v_ff)     st4_ff <= st4_in;
      if (st5_rdy && f1_out_valid) st5_ff <= st5_in;
      if (st6_rdy && st5_v_ff)     st6_ff <= st6_in;
      if (st7_rdy && f2_out_valid) st7_ff <= st7_in;
      if (st8_rdy && st7_v_ff)     st8_ff <= st8_in;
      if (st9_rdy && st8_v_ff)     st9_ff <= st9_in;
   end

   // stage 1: unpack, differences, squared radius sum
   logic [RS_W-1:0] rs;
   assign rs = RS_W'(req_data.radius_a) + RS_W'(req_data.radius_b);

   always_comb begin
      st1_in = '0;
      for (int k = 0; k < 3; k++) begin
         st1_in.geo.p1[k] = coord_of(req_data.seg_a_start, k);
         st1_in.geo.q1[k] = coord_of(req_data.seg_b_start, k);
         st1_in.geo.d1[k] = DIFF_W'($signed(coord_of(req_data.seg_a_end, k)))
                          - DIFF_W'($signed(coord_of(req_data.seg_a_start, k)));
         st1_in.geo.d2[k] = DIFF_W'($signed(coord_of(req_data.seg_b_end, k)))
                          - DIFF_W'($signed(coord_of(req_data.seg_b_start, k)));
         st1_in.r[k]      = DIFF_W'($signed(coord_of(req_data.seg_a_start, k)))
                          - DIFF_W'($signed(coord_of(req_data.seg_b_start, k)));
      end
      st1_in.rs2 = rs * rs;
   end

   // stage 2: dot products
   always_comb begin
      st2_in.geo = st1_ff.geo;
      st2_in.rs2 = st1_ff.rs2;
      st2_in.a   = dot3(st1_ff.geo.d1, st1_ff.geo.d1);
      st2_in.b   = dot3(st1_ff.geo.d1, st1_ff.geo.d2);
      st2_in.c   = dot3(st1_ff.geo.d1, st1_ff.r);
      st2_in.e   = dot3(st1_ff.geo.d2, st1_ff.geo.d2);
      st2_in.f   = dot3(st1_ff.geo.d2, st1_ff.r);
   end

   // stage 3: cross products and degenerate flags
   always_comb begin
      st3_in.side.dots  = st2_ff;
      st3_in.side.deg_a = st2_ff.a < $signed({(DOT_W-LIM_W)'(0), lim});
      st3_in.side.deg_e = st2_ff.e < $signed({(DOT_W-LIM_W)'(0), lim});
      st3_in.ae = st2_ff.a * st2_ff.e;
      st3_in.bb = st2_ff.b * st2_ff.b;
      st3_in.bf = st2_ff.b * st2_ff.f;
      st3_in.ce = st2_ff.c * st2_ff.e;
   end

   // stage 4: denominator and numerator of the unclamped s
   logic signed [WIDE_W-1:0] den_w;
   assign den_w = st3_ff.ae - st3_ff.bb;

   always_comb begin
      st4_in.side = st3_ff.side;
      // parallel segments give s = 0
      if (den_w[WIDE_W-1] || den_w == '0) begin
         st4_in.num = '0;
         st4_in.den = WIDE_W'(1);
      end else begin
         st4_in.num = st3_ff.bf - st3_ff.ce;
         st4_in.den = den_w;
      end
   end

   cco_frac #(
      .NUM_W  (WIDE_W),
      .SIDE_W ($bits(side1_type))
   ) u_frac_s (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st4_v_ff),
      .in_ready  (f1_in_ready),
      .in_num    (st4_ff.num),
      .in_den    (st4_ff.den),
      .in_side   (st4_ff.side),
      .out_valid (f1_out_valid),
      .out_ready (st5_rdy),
      .out_q     (f1_q),
      .out_side  (f1_side_out)
   );

   assign f1_side = f1_side_out;

   // stage 5: numerator of t for the unclamped s
   always_comb begin
      st5_in.side = f1_side;
      st5_in.s0   = f1_q;
      st5_in.tnum = TNUM_W'(f1_side.dots.b * $signed({1'b0, f1_q}))
                  + TNUM_W'($signed({f1_side.dots.f, 16'b0}));
   end

   // stage 6: pick which parameter the second division gives
   logic signed [TNUM_W-1:0] e16, a_x, c_x, b_x, f_x;
   assign e16 = TNUM_W'($signed({st5_ff.side.dots.e, 16'b0}));
   assign a_x = TNUM_W'(st5_ff.side.dots.a);
   assign b_x = TNUM_W'(st5_ff.side.dots.b);
   assign c_x = TNUM_W'(st5_ff.side.dots.c);
   assign f_x = TNUM_W'(st5_ff.side.dots.f);

   always_comb begin
      st6_in.side.geo   = st5_ff.side.dots.geo;
      st6_in.side.rs2   = st5_ff.side.dots.rs2;
      st6_in.side.tgt_t = 1'b0;
      st6_in.side.fixed = '0;
      st6_in.num        = '0;
      st6_in.den        = TNUM_W'(1);
      if (st5_ff.side.deg_a && st5_ff.side.deg_e) begin
         st6_in.num = '0;
      end else if (st5_ff.side.deg_a) begin
         st6_in.side.tgt_t = 1'b1;
         st6_in.num        = f_x;
         st6_in.den        = TNUM_W'(st5_ff.side.dots.e);
      end else if (st5_ff.side.deg_e || st5_ff.tnum[TNUM_W-1]) begin
         st6_in.num = -c_x;
         st6_in.den = a_x;
      end else if (st5_ff.tnum > e16) begin
         // projection beyond the end of the second segment
         st6_in.side.fixed = ONE_Q16;
         st6_in.num        = b_x - c_x;
         st6_in.den        = a_x;
      end else begin
         st6_in.side.tgt_t = 1'b1;
         st6_in.side.fixed = st5_ff.s0;
         st6_in.num        = st5_ff.tnum;
         st6_in.den        = e16;
      end
   end

   cco_frac #(
      .NUM_W  (TNUM_W),
      .SIDE_W ($bits(side2_type))
   ) u_frac_st (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st6_v_ff),
      .in_ready  (f2_in_ready),
      .in_num    (st6_ff.num),
      .in_den    (st6_ff.den),
      .in_side   (st6_ff.side),
      .out_valid (f2_out_valid),
      .out_ready (st7_rdy),
      .out_q     (f2_q),
      .out_side  (f2_side_out)
   );

   assign f2_side = f2_side_out;

   // stage 7: closest points
   logic [PARAM_W-1:0] s_fin, t_fin;
   assign s_fin = f2_side.tgt_t ? f2_side.fixed : f2_q;
   assign t_fin = f2_side.tgt_t ? f2_q : f2_side.fixed;

   always_comb begin
      st7_in.s   = s_fin;
      st7_in.t   = t_fin;
      st7_in.rs2 = f2_side.rs2;
      for (int k = 0; k < 3; k++) begin
         st7_in.ca[k] = along(f2_side.geo.p1[k], f2_side.geo.d1[k], s_fin);
         st7_in.cb[k] = along(f2_side.geo.q1[k], f2_side.geo.d2[k], t_fin);
      end
   end

   // stage 8: squared coordinate differences
   always_comb begin
      logic signed [DIFF_W-1:0] df;
      st8_in.s   = st7_ff.s;
      st8_in.t   = st7_ff.t;
      st8_in.ca  = st7_ff.ca;
      st8_in.cb  = st7_ff.cb;
      st8_in.rs2 = st7_ff.rs2;
      for (int k = 0; k < 3; k++) begin
         df = DIFF_W'($signed(st7_ff.cb[k])) - DIFF_W'($signed(st7_ff.ca[k]));
         st8_in.sq[k] = SQ_W'(df * df);
      end
   end

   // stage 9: distance sum and overlap; the sum of three squares fits DIST_W without
   // wrapping since both points lie inside the coordinate range
   logic [DIST_W-1:0] dist_sum;
   assign dist_sum = DIST_W'(st8_ff.sq[0]) + DIST_W'(st8_ff.sq[1]) + DIST_W'(st8_ff.sq[2]);

   always_comb begin
      st9_in.overlap      = dist_sum <= DIST_W'(st8_ff.rs2);
      st9_in.param_s      = st8_ff.s;
      st9_in.param_t      = st8_ff.t;
      st9_in.closest_on_a = st8_ff.ca;
      st9_in.closest_on_b = st8_ff.cb;
      st9_in.dist_squared = dist_sum;
   end

endmodule

### sv/cco_check.sv
// port-level checker for the capsule overlap block, bound to the top level
// depends on cco_pkg and assert_macros.svh
`include "assert_macros.svh"

module cco_check import cco_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data))
   `ASSERT_CLK(a_param_range, rsp_valid |-> rsp_data.param_s <= ONE_Q16 && rsp_data.param_t <= ONE_Q16)
   `ASSERT_CLK(a_touch_overlaps, rsp_valid && rsp_data.dist_squared == '0 |-> rsp_data.overlap)
   `ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid)

endmodule

bind capsule_capsule_overlap_test cco_check u_cco_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### verif/tb.sv
// self-checking bench for capsule_capsule_overlap_test: directed table, then random pairs
// expected items come from a segment closest-point predictor kept in this file,
// unless a directed row carries its own result; depends on cco_pkg and the block's rtl
module tb import cco_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY_WAIT = 60;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1500;

   typedef struct {
      req_type pair;
      bit      typed;
      rsp_type result;
   } row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [LIM_W-1:0] csr_data;

   rsp_type    contact_queue[$];
   logic [LIM_W-1:0] limit_shadow;
   int         fail_count;
   int         items_sent;
   int         items_checked;
   int         cycle_count;
   int         idle_pct;
   int         stall_pct;
   row_type    directed[$];

   capsule_capsule_overlap_test DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint coord_at(logic [POINT_W-1:0] p, int k);
      return longint'($signed(p[16*k +: 16]));
   endfunction

   function automatic logic [POINT_W-1:0] point3(int x, int y, int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   // clamped quotient to q1.16, den > 0
   function automatic longint clamp_ratio(logic signed [127:0] num, logic signed [127:0] den);
      if (num <= 0) return 0;
      if (num >= den) return 65536;
      return longint'((num <<< 16) / den);
   endfunction

   function automatic longint point_along(longint start, longint d, longint p);
      longint pr;
      pr = d * p + 32768;
      return start + (pr >>> 16);
   endfunction

   function automatic rsp_type predict_contact(req_type q, logic [LIM_W-1:0] lim_reg);
      longint p1[3], d1[3], q1[3], d2[3], r[3], ca[3], cb[3];
      longint a, b, c, e, f, lim, tnum, dsum, rs, df, s, t;
      logic signed [127:0] den;
      rsp_type o;
      a = 0; b = 0; c = 0; e = 0; f = 0; dsum = 0; s = 0; t = 0;
      o = '0;
      for (int k = 0; k < 3; k++) begin
         p1[k] = coord_at(q.seg_a_start, k);
         d1[k] = coord_at(q.seg_a_end, k) - p1[k];
         q1[k] = coord_at(q.seg_b_start, k);
         d2[k] = coord_at(q.seg_b_end, k) - q1[k];
         r[k]  = p1[k] - q1[k];
         a += d1[k] * d1[k];
         e += d2[k] * d2[k];
         f += d2[k] * r[k];
         c += d1[k] * r[k];
         b += d1[k] * d2[k];
      end
      lim = (lim_reg == 0) ? 1 : longint'(lim_reg);
      if (a < lim && e < lim) begin
         s = 0; t = 0;
      end else if (a < lim) begin
         t = clamp_ratio(f, e);
      end else if (e < lim) begin
         s = clamp_ratio(-c, a);
      end else begin
         den = 128'(a) * 128'(e) - 128'(b) * 128'(b);
         // parallel segments start from s = 0
         if (den <= 0) s = 0;
         else s = clamp_ratio(128'(b) * 128'(f) - 128'(c) * 128'(e), den);
         tnum = b * s + f * 65536;
         if (tnum < 0) begin
            t = 0;
            s = clamp_ratio(-c, a);
         end else if (tnum > e * 65536) begin
            t = 65536;
            s = clamp_ratio(b - c, a);
         end else begin
            t = tnum / e;
         end
      end
      for (int k = 0; k < 3; k++) begin
         ca[k] = point_along(p1[k], d1[k], s);
         cb[k] = point_along(q1[k], d2[k], t);
         df = cb[k] - ca[k];
         dsum += df * df;
         o.closest_on_a[16*k +: 16] = ca[k][15:0];
         o.closest_on_b[16*k +: 16] = cb[k][15:0];
      end
      if (dsum > 64'hFF_FFFF_FFFF) dsum = 64'hFF_FFFF_FFFF;
      rs = longint'(q.radius_a) + longint'(q.radius_b);
      o.overlap      = (dsum <= rs * rs);
      o.param_s      = PARAM_W'(s);
      o.param_t      = PARAM_W'(t);
      o.dist_squared = DIST_W'(dsum);
      return o;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // result side: random backpressure, comparison against the oldest expected item
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (contact_queue.size() == 0) begin
            $error("result item with nothing expected");
            fail_count++;
         end else begin
            want = contact_queue.pop_front();
            items_checked++;
            check_field("overlap", 64'(want.overlap), 64'(rsp_data.overlap));
            check_field("param_s", 64'(want.param_s), 64'(rsp_data.param_s));
            check_field("param_t", 64'(want.param_t), 64'(rsp_data.param_t));
            check_field("closest_on_a", 64'(want.closest_on_a), 64'(rsp_data.closest_on_a));
            check_field("closest_on_b", 64'(want.closest_on_b), 64'(rsp_data.closest_on_b));
            check_field("dist_squared", 64'(want.dist_squared), 64'(rsp_data.dist_squared));
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_pair(req_type x, bit typed, rsp_type typed_result);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= x;
      do @(posedge clock); while (!req_ready);
      contact_queue.push_back(typed ? typed_result : predict_contact(x, limit_shadow));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_limit(logic [LIM_W-1:0] value);
      req_valid <= 1'b0;
      while (contact_queue.size() != 0) @(negedge clock);
      repeat (LATENCY_WAIT) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      limit_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int rand_coord(int span);
      if (span >= 32768) return int'($urandom_range(65535));
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic logic [POINT_W-1:0] rand_point(int span);
      return point3(rand_coord(span), rand_coord(span), rand_coord(span));
   endfunction

   function automatic logic [POINT_W-1:0] shift_point(logic [POINT_W-1:0] p, int dx, int dy,
                                                     int dz);
      return point3(int'(coord_at(p, 0)) + dx, int'(coord_at(p, 1)) + dy,
                    int'(coord_at(p, 2)) + dz);
   endfunction

   function automatic req_type random_pair();
      req_type x;
      int span, kind, dx, dy, dz, m;
      kind = $urandom_range(9);
      span = ($urandom_range(9) == 0) ? 32768 : (1 << $urandom_range(4, 12));
      x.seg_a_start = rand_point(span);
      x.seg_a_end   = rand_point(span);
      x.seg_b_start = rand_point(span);
      x.seg_b_end   = rand_point(span);
      case (kind)
         0: x.seg_a_end = x.seg_a_start;
         1: x.seg_b_end = x.seg_b_start;
         2: x.seg_a_end = shift_point(x.seg_a_start, rand_coord(1), rand_coord(1),
                                      rand_coord(1));
         3: begin
            // parallel or antiparallel copy of the first direction
            dx = int'(coord_at(x.seg_a_end, 0) - coord_at(x.seg_a_start, 0));
            dy = int'(coord_at(x.seg_a_end, 1) - coord_at(x.seg_a_start, 1));
            dz = int'(coord_at(x.seg_a_end, 2) - coord_at(x.seg_a_start, 2));
            m  = $urandom_range(1) ? 1 : -1;
            x.seg_b_end = shift_point(x.seg_b_start, m * dx, m * dy, m * dz);
         end
         default: ;
      endcase
      x.radius_a = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(span));
      x.radius_b = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(span));
      return x;
   endfunction

   task automatic add_row(logic [POINT_W-1:0] as, logic [POINT_W-1:0] ae,
                          logic [POINT_W-1:0] bs, logic [POINT_W-1:0] be,
                          logic [RAD_W-1:0] ra, logic [RAD_W-1:0] rb,
                          bit typed, rsp_type res);
      row_type row;
      row.pair   = '{as, ae, bs, be, ra, rb};
      row.typed  = typed;
      row.result = res;
      directed.push_back(row);
   endtask

   initial begin
      logic [LIM_W-1:0] limits[4];
      req_valid = 1'b0; req_data = '0; rsp_ready = 1'b0;
      csr_valid = 1'b0; csr_data = '0;
      fail_count = 0; items_sent = 0; items_checked = 0; cycle_count = 0;
      idle_pct = 14; stall_pct = 14;
      limit_shadow = LIMIT_RESET;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // both segments points at the origin
      add_row('0, '0, '0, '0, 16'h0, 16'h0, 1, '{1'b1, 17'd0, 17'd0, '0, '0, 40'd0});
      // two points one unit apart, radii summing to exactly one
      add_row(point3(256, 0, 0), point3(256, 0, 0), '0, '0, 16'h80, 16'h80, 1,
              '{1'b1, 17'd0, 17'd0, point3(256, 0, 0), '0, 40'h10000});
      add_row(point3(256, 0, 0), point3(256, 0, 0), '0, '0, 16'h80, 16'h7F, 1,
              '{1'b0, 17'd0, 17'd0, point3(256, 0, 0), '0, 40'h10000});
      // extremes of the coordinate range
      add_row(point3(32767, 32767, 32767), point3(-32768, -32768, -32768),
              point3(-32768, 32767, -32768), point3(32767, -32768, 32767),
              16'hFFFF, 16'hFFFF, 0, '0);
      add_row(point3(-32768, -32768, -32768), point3(-32768, -32768, -32768),
              point3(32767, 32767, 32767), point3(32767, 32767, 32767),
              16'hFFFF, 16'hFFFF, 0, '0);
      add_row(point3(32767, -32768, 0), point3(-32768, 32767, 0),
              point3(-32768, -32768, 32767), point3(32767, 32767, -32768), 0, 0, 0, '0);
      // crossing segments
      add_row(point3(-512, 0, 0), point3(512, 0, 0), point3(0, -512, 256),
              point3(0, 512, 256), 16'h80, 16'h80, 0, '0);
      // parallel and antiparallel
      add_row(point3(0, 0, 0), point3(1024, 0, 0), point3(0, 256, 0),
              point3(1024, 256, 0), 16'h40, 16'h40, 0, '0);
      add_row(point3(0, 0, 0), point3(1024, 0, 0), point3(2048, 256, 0),
              point3(1536, 256, 0), 16'h100, 16'h100, 0, '0);
      // first segment a point, then second a point
      add_row(point3(100, 300, -50), point3(100, 300, -50), point3(-400, 0, 0),
              point3(400, 0, 0), 16'h10, 16'h20, 0, '0);
      add_row(point3(-400, 0, 0), point3(400, 0, 0), point3(100, 300, -50),
              point3(100, 300, -50), 16'h10, 16'h20, 0, '0);
      add_row(point3(-400, 0, 0), point3(400, 0, 0), point3(900, 300, 0),
              point3(900, 300, 0), 16'h10, 16'h20, 0, '0);
      // projection before and beyond the second segment
      add_row(point3(0, 0, 0), point3(256, 0, 0), point3(-1000, 100, 0),
              point3(-2000, 900, 0), 16'h1, 16'h1, 0, '0);
      add_row(point3(0, 0, 0), point3(256, 0, 0), point3(2000, 900, 0),
              point3(1000, 100, 0), 16'h1, 16'h1, 0, '0);
      // length one lsb: degenerate at the reset limit only when zero
      add_row(point3(5, 5, 5), point3(6, 5, 5), point3(-3, 9, 1), point3(7, -2, 4),
              16'h3, 16'h3, 0, '0);
      add_row(point3(7, 1, 2), point3(7, 1, 3), point3(7, 1, 2), point3(7, 2, 3),
              16'h0, 16'h0, 0, '0);

      foreach (directed[i]) send_pair(directed[i].pair, directed[i].typed, directed[i].result);

      limits[0] = 16'h0;
      limits[1] = 16'hFFFF;
      limits[2] = 16'($urandom);
      limits[3] = LIMIT_RESET;
      for (int ph = 0; ph < 4; ph++) begin
         write_limit(limits[ph]);
         for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
            // a calm stretch with no idling on either side
            if (ph == 1 && i == 100) begin
               idle_pct = 0; stall_pct = 0;
            end
            if (ph == 1 && i == 300) begin
               idle_pct = 14; stall_pct = 14;
            end
            send_pair(random_pair(), 0, '0);
         end
      end
      req_valid <= 1'b0;

      while (contact_queue.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
      $display("sent %0d capsule pairs, %0d results checked", items_sent, items_checked);
      $display("degenerate limits 1, 0, 65535, random; directed corner rows first");
      if (fail_count == 0 && contact_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
